// File: rtl/nsed_pkg.sv
// package for the next smaller-or-equal discount unit
// holds sizes, beat and entry structs, sequencer states and stack request type
// no dependencies
package nsed_pkg;

    // sequence limit and price width in use
    localparam int MAX_ITEMS  = 64;
    localparam int PRICE_BITS = 16;

    // fixed field widths
    localparam int PRICE_W = 16;
    localparam int IDX_W   = 6;

    // derived sizes
    localparam int ADDR_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int DEPTH_W  = $clog2(MAX_ITEMS + 1);
    localparam int CNT_W    = ADDR_W;
    localparam int USE_BITS = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;

    localparam logic [PRICE_W-1:0] PRICE_MASK = PRICE_W'((64'd1 << USE_BITS) - 64'd1);
    localparam logic [CNT_W-1:0]   LAST_IDX   = CNT_W'(MAX_ITEMS - 1);

    // input beat
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               last_item;
    } t_item;

    // output beat
    typedef struct packed {
        logic [IDX_W-1:0]   item_index;
        logic [PRICE_W-1:0] final_price;
        logic               sequence_done;
        logic               last_of_run;
    } t_result;

    // one waiting stack entry
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [PRICE_W-1:0] value;
    } t_entry;

    // stack memory access for one cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_stk_req;

    // compare and subtract result
    typedef struct packed {
        logic               ge;
        logic [PRICE_W-1:0] diff;
    } t_cmp;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_END,
        S_FRD,
        S_FOUT
    } t_state;

endpackage

// File: rtl/next_smaller_or_equal_discount_unit.sv
// top level of the next smaller-or-equal discount unit
// depends on nsed_pkg, nsed_ctrl, nsed_cmpsub, nsed_stack
//
//   channel   direction  handshake            beat
//   input     in         i_valid / o_ready    i_item   (price, last_item)
//   result    out        o_valid / i_ready    o_result (item_index, final_price,
//                                                       sequence_done, last_of_run)
//
// an item pops entries one at a time: each compare is one stack read (S_RD) plus one
// pass through the shared compare/subtract unit (S_CMP); after the pops the item is
// pushed (S_END); a last item then flushes each entry with a read (S_FRD) and an
// emit (S_FOUT), set by the single stack read port
// reset is synchronous, active low; it empties the stack and the result register
// a stalled result register holds the sequencer wherever it has a result to hand over
module next_smaller_or_equal_discount_unit
    import nsed_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic     out_free;
    logic     out_load;
    t_result  out_data;
    t_stk_req stk_req;
    t_entry   stk_rdata;

    logic     r_out_valid;
    t_result  r_out;

    // sequencer with its compare/subtract unit
    nsed_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_ready     (o_ready),
        .i_out_free  (out_free),
        .o_out_load  (out_load),
        .o_out_data  (out_data),
        .o_stk_req   (stk_req),
        .i_stk_rdata (stk_rdata)
    );

    // waiting index/value pairs
    nsed_stack u_stack (
        .i_clk   (i_clk),
        .i_req   (stk_req),
        .o_rdata (stk_rdata)
    );

    // result register
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: rtl/nsed_stack.sv
// stack storage: index/value pairs, one write and one registered read per cycle
// depends on nsed_pkg
module nsed_stack
    import nsed_pkg::*;
(
    input  logic     i_clk,
    input  t_stk_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [MAX_ITEMS];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/nsed_cmpsub.sv
// shared compare and subtract unit used on every pop
// depends on nsed_pkg
module nsed_cmpsub
    import nsed_pkg::*;
(
    input  logic [PRICE_W-1:0] i_a,
    input  logic [PRICE_W-1:0] i_b,
    output t_cmp               o_res
);

    // stacked value against new price
    assign o_res.ge   = (i_a >= i_b);
    assign o_res.diff = i_a - i_b;

endmodule

// File: rtl/nsed_ctrl.sv
// sequencer: pops resolved entries, pushes the new item, flushes on last
// depends on nsed_pkg, nsed_cmpsub
module nsed_ctrl
    import nsed_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_item    i_item,
    output logic     o_ready,
    input  logic     i_out_free,
    output logic     o_out_load,
    output t_result  o_out_data,
    output t_stk_req o_stk_req,
    input  t_entry   i_stk_rdata
);

    t_state               r_state, n_state;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [PRICE_W-1:0]   r_price, n_price;
    logic                 r_last, n_last;
    t_result              r_pend, n_pend;
    logic                 r_pend_valid, n_pend_valid;

    logic [DEPTH_W-1:0]   depth_m1;
    t_cmp                 cmp;

    assign depth_m1 = r_depth - DEPTH_W'(1);

    // the one compare/subtract unit
    nsed_cmpsub u_cmpsub (
        .i_a   (i_stk_rdata.value),
        .i_b   (r_price),
        .o_res (cmp)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_depth      <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_depth      <= n_depth;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
        end
    end

    // item and pending result payload
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_price <= n_price;
        r_last  <= n_last;
        r_pend  <= n_pend;
    end

    // next state and outputs
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_price      = r_price;
        n_last       = r_last;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        o_ready      = 1'b0;
        o_out_load   = 1'b0;
        o_out_data   = r_pend;
        o_stk_req    = '0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_price = i_item.price & PRICE_MASK;
                    n_last  = i_item.last_item | (r_cnt == LAST_IDX);
                    n_idx   = r_cnt;
                    n_state = (r_depth == '0) ? S_END : S_RD;
                end
            end

            // fetch top of stack
            S_RD: begin
                o_stk_req.re    = 1'b1;
                o_stk_req.raddr = depth_m1[ADDR_W-1:0];
                n_state         = S_CMP;
            end

            // pop if top >= new price; older pending result is not the run's last
            S_CMP: begin
                if (cmp.ge) begin
                    if (!r_pend_valid || i_out_free) begin
                        o_out_load                = r_pend_valid;
                        n_pend.item_index         = i_stk_rdata.idx;
                        n_pend.final_price        = cmp.diff;
                        n_pend.sequence_done      = 1'b0;
                        n_pend.last_of_run        = 1'b0;
                        n_pend_valid              = 1'b1;
                        n_depth                   = depth_m1;
                        n_state = (depth_m1 == '0) ? S_END : S_RD;
                    end
                end else begin
                    n_state = S_END;
                end
            end

            // release pending result and push the new item
            S_END: begin
                if (!r_pend_valid || i_out_free) begin
                    o_out_load             = r_pend_valid;
                    o_out_data.last_of_run = !r_last;
                    n_pend_valid           = 1'b0;
                    o_stk_req.we           = 1'b1;
                    o_stk_req.waddr        = r_depth[ADDR_W-1:0];
                    o_stk_req.wdata.idx    = IDX_W'(r_idx);
                    o_stk_req.wdata.value  = r_price;
                    n_depth                = r_depth + DEPTH_W'(1);
                    if (r_last) begin
                        n_cnt   = '0;
                        n_state = S_FRD;
                    end else begin
                        n_cnt   = r_idx + CNT_W'(1);
                        n_state = S_IDLE;
                    end
                end
            end

            // flush: fetch top
            S_FRD: begin
                o_stk_req.re    = 1'b1;
                o_stk_req.raddr = depth_m1[ADDR_W-1:0];
                n_state         = S_FOUT;
            end

            // flush: emit top unchanged
            S_FOUT: begin
                if (i_out_free) begin
                    o_out_load               = 1'b1;
                    o_out_data.item_index    = i_stk_rdata.idx;
                    o_out_data.final_price   = i_stk_rdata.value;
                    o_out_data.sequence_done = 1'b1;
                    o_out_data.last_of_run   = (depth_m1 == '0);
                    n_depth                  = depth_m1;
                    n_state = (depth_m1 == '0) ? S_IDLE : S_FRD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/nsed_checker.sv
// port checker for the next smaller-or-equal discount unit, bound to the top level
// depends on nsed_pkg and next_smaller_or_equal_discount_unit
module nsed_checker
    import nsed_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_valid,
    input logic    o_ready,
    input t_item   i_item,
    input logic    o_valid,
    input logic    i_ready,
    input t_result o_result
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("result beat changed while stalled");

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_item))
        else $error("input beat changed while waiting");

    // reset leaves an empty result register and an idle sequencer
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not empty after reset");

    // one item at a time: an accepted beat drops ready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an accepted beat");

    // result index never passes the sequence limit
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_result.item_index) <= MAX_ITEMS - 1))
        else $error("result index beyond sequence limit");

endmodule

bind next_smaller_or_equal_discount_unit nsed_checker u_nsed_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_result (o_result)
);
